[hw/rtl/base64_stream_encoder_top_assert.svh]
// assertion macros used by the encoder back end
// each macro expects clk and rst to be visible where it is used
`ifndef BASE64_STREAM_ENCODER_TOP_ASSERT_SVH
`define BASE64_STREAM_ENCODER_TOP_ASSERT_SVH

// same-cycle implication
`define B64E_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define B64E_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/b64enc_pkg.sv]
// types, constants and the sextet alphabet for the base64 encoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package b64enc_pkg;

  localparam int unsigned JobChars = 4;
  localparam int unsigned QueueDepth = 2;
  localparam logic [6:0] PAD_CHAR = 7'h3D;
  localparam logic [6:0] PLUS_CHAR = 7'h2B;
  localparam logic [6:0] SLASH_CHAR = 7'h2F;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_word_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       run_last;
    logic       message_end;
  } out_word_t;

  typedef struct packed {
    logic [JobChars-1:0][6:0] chars;
    logic [1:0]               last_idx;
    logic                     fin;
  } job_t;

  typedef enum logic [1:0] {
    PHASE_START = 2'd0,
    PHASE_ONE   = 2'd1,
    PHASE_TWO   = 2'd2
  } phase_t;

  function automatic logic [6:0] sextet_char(input logic [5:0] v);
    logic [6:0] ch;
    if (v < 6'd26) begin
      ch = 7'd65 + {1'b0, v};
    end else if (v < 6'd52) begin
      ch = 7'd71 + {1'b0, v};
    end else if (v < 6'd62) begin
      ch = {1'b0, v} - 7'd4;
    end else if (v == 6'd62) begin
      ch = PLUS_CHAR;
    end else begin
      ch = SLASH_CHAR;
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/b64enc_front.sv]
// front end: accepts message bytes, tracks group phase and carry bits
// and builds one character job per byte; uses b64enc_pkg
`timescale 1ns / 1ps
`default_nettype none

module b64enc_front
  import b64enc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     take,
  input  in_word_t word,
  output job_t     job
);

  phase_t     phase, phase_next;
  logic [3:0] carry, carry_next;
  logic [7:0] b;
  logic       fin;

  assign b   = word.data_byte;
  assign fin = word.final_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PHASE_START;
      carry <= 4'd0;
    end else if (take) begin
      phase <= phase_next;
      carry <= carry_next;
    end
  end

  // next state
  always_comb begin
    phase_next = PHASE_START;
    carry_next = 4'd0;
    if (!fin) begin
      case (phase)
        PHASE_ONE: begin
          phase_next = PHASE_TWO;
          carry_next = b[3:0];
        end
        PHASE_TWO: begin
          phase_next = PHASE_START;
          carry_next = 4'd0;
        end
        default: begin
          phase_next = PHASE_ONE;
          carry_next = {2'b00, b[1:0]};
        end
      endcase
    end
  end

  // job contents
  always_comb begin
    job.chars    = {JobChars{PAD_CHAR}};
    job.last_idx = 2'd0;
    job.fin      = fin;
    case (phase)
      PHASE_ONE: begin
        job.chars[0] = sextet_char({carry[1:0], b[7:4]});
        if (fin) begin
          job.chars[1] = sextet_char({b[3:0], 2'b00});
          job.last_idx = 2'd2;
        end
      end
      PHASE_TWO: begin
        job.chars[0] = sextet_char({carry, b[7:6]});
        job.chars[1] = sextet_char(b[5:0]);
        job.last_idx = 2'd1;
      end
      default: begin
        job.chars[0] = sextet_char(b[7:2]);
        if (fin) begin
          job.chars[1] = sextet_char({b[1:0], 4'b0000});
          job.last_idx = 2'd3;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/b64enc_queue.sv]
// two-entry job queue between front and back ends
// uses b64enc_pkg
`timescale 1ns / 1ps
`default_nettype none

module b64enc_queue
  import b64enc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output job_t head
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  job_t            slots [QueueDepth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;

  assign full       = (count == CntW'(QueueDepth));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/b64enc_back.sv]
// back end: walks the head job one character a cycle, unless the output is stalled, into the output register
// uses b64enc_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none

`include "base64_stream_encoder_top_assert.svh"

module b64enc_back
  import b64enc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      head_valid,
  input  job_t      head,
  output logic      pop,
  output logic      valid,
  input  logic      stall,
  output out_word_t word
);

  logic [1:0] idx;
  logic       load;
  logic       at_last;

  assign load    = head_valid && (!valid || !stall);
  assign at_last = (idx == head.last_idx);
  assign pop     = load && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= 2'd0;
    end else if (load) begin
      valid <= 1'b1;
      idx   <= at_last ? 2'd0 : idx + 2'd1;
    end else if (!stall) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word.out_char    <= head.chars[idx];
      word.run_last    <= at_last;
      word.message_end <= at_last && head.fin;
    end
  end

  `B64E_ASSERT_IMP(a_idx_in_job, head_valid, idx <= head.last_idx,
                   "character index beyond job end")
  `B64E_ASSERT_NXT(a_drain_empty, valid && !stall && !head_valid, !valid,
                   "output stayed valid with nothing to send")
  `B64E_ASSERT_NXT(a_run_last_match, load,
                   valid && (word.run_last == ($past(idx) == $past(head.last_idx))),
                   "run_last does not match job end")
  `B64E_ASSERT_IMP(a_end_is_last, valid && word.message_end, word.run_last,
                   "message end without run end")

endmodule

`default_nettype wire

[hw/rtl/base64_stream_encoder_top.sv]
// base64 stream encoder: one byte per word in, one character per word out
// a byte's job is written into the job queue, then its characters into the back-end output register
// throughput: one character per cycle while dst_stall is low, set by the back-end serialiser;
// one to four characters per byte
// reset clears group phase, carry bits, job queue and output valid
// depends on b64enc_pkg, b64enc_front, b64enc_queue, b64enc_back
`timescale 1ns / 1ps
`default_nettype none

module base64_stream_encoder_top
  import b64enc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      src_valid,
  output logic      src_stall,
  input  in_word_t  src_word,
  output logic      dst_valid,
  input  logic      dst_stall,
  output out_word_t dst_word
);

  logic take;
  logic full;
  logic head_valid;
  logic pop;
  job_t new_job;
  job_t head;

  assign src_stall = full;
  assign take      = src_valid && !full;

  b64enc_front u_front (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .word (src_word),
    .job  (new_job)
  );

  b64enc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (take),
    .push_job   (new_job),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  b64enc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .valid      (dst_valid),
    .stall      (dst_stall),
    .word       (dst_word)
  );

endmodule

`default_nettype wire

[tb/tb_base64_stream_encoder_top.sv]
// self-checking testbench for base64_stream_encoder_top: directed and random messages
// with random idling on both channels; a scoreboard class predicts every character
// depends on b64enc_pkg and base64_stream_encoder_top
`timescale 1ns / 1ps
`default_nettype none

module tb_base64_stream_encoder_top;
  import b64enc_pkg::*;

  localparam int unsigned RandomBytes = 350;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 60;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned IdlePercent = 21;

  class b64_scoreboard;
    phase_t    phase;
    logic [3:0] carry;
    out_word_t expected_chars[$];
    int        errors;
    int        checked;
    string     alphabet;

    function new();
      phase = PHASE_START;
      carry = '0;
      errors = 0;
      checked = 0;
      alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    endfunction

    function logic [6:0] to_char(logic [5:0] v);
      byte c;
      c = alphabet[v];
      return c[6:0];
    endfunction

    function void note_byte(in_word_t w);
      logic [6:0] chars[$];
      out_word_t  e;
      case (phase)
        PHASE_ONE: begin
          chars.push_back(to_char({carry[1:0], w.data_byte[7:4]}));
          if (w.final_byte) begin
            chars.push_back(to_char({w.data_byte[3:0], 2'b00}));
            chars.push_back(PAD_CHAR);
          end else begin
            carry = w.data_byte[3:0];
            phase = PHASE_TWO;
          end
        end
        PHASE_TWO: begin
          chars.push_back(to_char({carry, w.data_byte[7:6]}));
          chars.push_back(to_char(w.data_byte[5:0]));
          carry = '0;
          phase = PHASE_START;
        end
        default: begin
          chars.push_back(to_char(w.data_byte[7:2]));
          if (w.final_byte) begin
            chars.push_back(to_char({w.data_byte[1:0], 4'b0000}));
            chars.push_back(PAD_CHAR);
            chars.push_back(PAD_CHAR);
          end else begin
            carry = {2'b00, w.data_byte[1:0]};
            phase = PHASE_ONE;
          end
        end
      endcase
      if (w.final_byte) begin
        phase = PHASE_START;
        carry = '0;
      end
      foreach (chars[i]) begin
        e.out_char = chars[i];
        e.run_last = (i == chars.size() - 1);
        e.message_end = w.final_byte && (i == chars.size() - 1);
        expected_chars.push_back(e);
      end
    endfunction

    function void check_char(out_word_t got);
      out_word_t e;
      if (expected_chars.size() == 0) begin
        $error("unexpected word: out_char %h run_last %b message_end %b",
               got.out_char, got.run_last, got.message_end);
        errors++;
        return;
      end
      e = expected_chars.pop_front();
      checked++;
      if (got.out_char !== e.out_char) begin
        $error("out_char expected %h actual %h", e.out_char, got.out_char);
        errors++;
      end
      if (got.run_last !== e.run_last) begin
        $error("run_last expected %b actual %b", e.run_last, got.run_last);
        errors++;
      end
      if (got.message_end !== e.message_end) begin
        $error("message_end expected %b actual %b", e.message_end, got.message_end);
        errors++;
      end
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      src_valid;
  logic      src_stall;
  in_word_t  src_word;
  logic      dst_valid;
  logic      dst_stall;
  out_word_t dst_word;

  b64_scoreboard sb;
  bit  quiet;
  bit  hold_req;
  int  cycles;
  int  bytes_sent;
  int  messages_sent;

  base64_stream_encoder_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_word  (src_word),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_word  (dst_word)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] data, input logic fin);
    in_word_t w;
    w.data_byte = data;
    w.final_byte = fin;
    @(negedge clk);
    while (!quiet && $urandom_range(0, 99) < IdlePercent) begin
      src_valid <= 1'b0;
      @(posedge clk);
      @(negedge clk);
    end
    src_valid <= 1'b1;
    src_word <= w;
    do @(posedge clk); while (src_stall);
    sb.note_byte(w);
    bytes_sent++;
    if (fin) messages_sent++;
  endtask

  task automatic send_message(input logic [7:0] bytes[$]);
    foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    src_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // receiver: random stall, plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    dst_stall = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        dst_stall <= 1'b1;
        hold_left--;
      end else begin
        dst_stall <= !quiet && ($urandom_range(0, 99) < IdlePercent);
      end
      @(posedge clk);
      if (dst_valid && !dst_stall) sb.check_char(dst_word);
    end
  end

  initial begin
    int         count;
    int         len;
    logic [7:0] msg[$];
    sb = new();
    cycles = 0;
    bytes_sent = 0;
    messages_sent = 0;
    quiet = 1'b0;
    hold_req = 1'b0;
    rst = 1'b1;
    src_valid = 1'b0;
    src_word = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // final byte at each group phase, extreme values, '+' and '/'
    send_message('{8'h00});
    send_message('{8'hFF});
    send_message('{8'h00, 8'hFF});
    send_message('{8'hFF, 8'h00});
    send_message('{8'hFB, 8'hEF, 8'hBE});
    send_message('{8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00});
    send_message('{8'h80, 8'h7F, 8'h01, 8'h55});
    send_message('{8'h01, 8'hFE});
    wait_drained();

    count = 0;
    while (count < RandomBytes) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
      msg.delete();
      repeat (len) msg.push_back(8'($urandom_range(0, 255)));
      foreach (msg[i]) begin
        quiet = (count >= 120 && count < 180);
        if (count == 250) hold_req = 1'b1;
        if (count == 80 || count == 300) wait_drained();
        send_byte(msg[i], i == msg.size() - 1);
        count++;
      end
    end
    wait_drained();
    repeat (DrainCycles) @(posedge clk);

    $display("sent %0d bytes in %0d messages, checked %0d characters",
             bytes_sent, messages_sent, sb.checked);
    $display("included a long output hold-off, a quiet stretch and drain pauses");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
